@@ hw/rtl/rpi_pkg.sv @@
// Shared constants and types for the ray/plane intersection unit.
`timescale 1ns / 1ps

package rpi_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // Fixed field widths
    localparam int NRM_W     = 18;
    localparam int ORG_W     = 32;
    localparam int OFS_W     = 32;
    localparam int EPS_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    // |t| is held in 62 bits, |d| as floor(sqrt(d.d)) in 32 bits
    localparam int QUOT_W = 62;
    localparam int ROOT_W = 32;
    localparam int DD_W   = 64;

    typedef enum logic [1:0] {
        ST_HIT      = 2'd0,
        ST_PARALLEL = 2'd1,
        ST_BEHIND   = 2'd2,
        ST_FAR      = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NORMAL_X = 3'd0,
        CFG_NORMAL_Y = 3'd1,
        CFG_NORMAL_Z = 3'd2,
        CFG_OFFSET   = 3'd3,
        CFG_EPSILON  = 3'd4
    } t_cfg_idx;

endpackage

@@ hw/rtl/ray_plane_intersect_top.sv @@
// Top level of the fixed-point ray/plane intersection pipeline.
`timescale 1ns / 1ps

// Ray/plane intersection unit. The plane N.p + D = 0 is held in five
// configuration registers (normal x/y/z, offset, epsilon), written over the
// cfg port, which is always ready; write them only while no transaction is in
// flight. Each input transaction gives exactly one result, in order. Kind 0
// intersects a ray with the plane and reports hit, parallel or behind-origin
// with the hit point and distance; kind 1 reports |N.p + D| for a point and
// whether it is near. The pipeline takes one transaction per clock while the
// output is not stalled. It has 3 stages of dot products and set-up, 62 stages
// of the restoring divider that produces |t| one quotient bit per stage (the
// 32-step square root of d.d runs in the first 32 of them), and 3 stages of
// scaling, saturation and result select. Stalls on the output back up stage by
// stage; empty stages keep accepting, so nothing is lost or repeated.

module ray_plane_intersect_top #(
    parameter int FRAC_BITS = rpi_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rpi_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [rpi_pkg::CFG_DAT_W-1:0]       i_cfg_data,
    // input transactions
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_kind,
    input  logic signed [rpi_pkg::ORG_W-1:0]    i_origin_x,
    input  logic signed [rpi_pkg::ORG_W-1:0]    i_origin_y,
    input  logic signed [rpi_pkg::ORG_W-1:0]    i_origin_z,
    input  logic signed [rpi_pkg::ORG_W-1:0]    i_dir_x,
    input  logic signed [rpi_pkg::ORG_W-1:0]    i_dir_y,
    input  logic signed [rpi_pkg::ORG_W-1:0]    i_dir_z,
    // results
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [1:0]                          o_status,
    output logic signed [rpi_pkg::ORG_W-1:0]    o_hit_x,
    output logic signed [rpi_pkg::ORG_W-1:0]    o_hit_y,
    output logic signed [rpi_pkg::ORG_W-1:0]    o_hit_z,
    output logic [rpi_pkg::ORG_W-1:0]           o_range
);

    localparam int NRM_W   = rpi_pkg::NRM_W;
    localparam int ORG_W   = rpi_pkg::ORG_W;
    localparam int OFS_W   = rpi_pkg::OFS_W;
    localparam int EPS_W   = rpi_pkg::EPS_W;
    localparam int QW      = rpi_pkg::QUOT_W;
    localparam int RW      = rpi_pkg::ROOT_W;
    localparam int DW      = rpi_pkg::DD_W;
    localparam int PROD_W  = NRM_W + ORG_W;
    localparam int MAG_W   = ((PROD_W > ORG_W - 1 + FRAC_BITS) ? PROD_W
                                                             : ORG_W - 1 + FRAC_BITS) + 1;
    localparam int DOT_W   = MAG_W + 1;
    localparam int EPS2_W  = EPS_W + FRAC_BITS;
    localparam int CLP_W   = EPS2_W + 1;
    localparam int AL      = (CLP_W + 1) / 2;
    localparam int AH      = CLP_W - AL;
    localparam int BH_W    = AH + CLP_W;
    localparam int BL_W    = AL + CLP_W;
    localparam int BP_W    = 2 * CLP_W;
    localparam int HALF_W  = QW / 2;
    localparam int MUL_W   = HALF_W + ORG_W;
    localparam int MPR_W   = MUL_W + HALF_W;
    localparam int HC_W    = DW + 2;
    localparam int SIDE_W  = 5 + ORG_W + 3 * ORG_W + 3 + 3 * ORG_W + CLP_W;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic signed [NRM_W-1:0] r_nx, r_ny, r_nz;
    logic signed [OFS_W-1:0] r_d;
    logic [EPS_W-1:0]        r_eps;
    logic [EPS2_W-1:0]       w_eps2;

    assign o_cfg_ready = 1'b1;
    assign w_eps2      = {r_eps, {FRAC_BITS{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nx  <= '0;
            r_ny  <= '0;
            r_nz  <= NRM_W'(1) << FRAC_BITS;
            r_d   <= '0;
            r_eps <= EPS_W'(7);
        end else if (i_cfg_valid) begin
            case (rpi_pkg::t_cfg_idx'(i_cfg_index))
                rpi_pkg::CFG_NORMAL_X: begin
                    r_nx <= i_cfg_data[NRM_W-1:0];
                end
                rpi_pkg::CFG_NORMAL_Y: begin
                    r_ny <= i_cfg_data[NRM_W-1:0];
                end
                rpi_pkg::CFG_NORMAL_Z: begin
                    r_nz <= i_cfg_data[NRM_W-1:0];
                end
                rpi_pkg::CFG_OFFSET: begin
                    r_d <= i_cfg_data[OFS_W-1:0];
                end
                rpi_pkg::CFG_EPSILON: begin
                    r_eps <= i_cfg_data[EPS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Stage enables: a stage loads when it is empty or its successor loads
    // ---------------------------------------------------------------
    logic r_s1_v, r_s2_v, r_s3_v, r_p1_v, r_p2_v, r_o_v;
    logic w_en_s1, w_en_s2, w_en_s3, w_en_p1, w_en_p2, w_en_o;
    logic w_ds_ready, w_ds_valid;

    assign w_en_o     = !r_o_v  || i_out_ready;
    assign w_en_p2    = !r_p2_v || w_en_o;
    assign w_en_p1    = !r_p1_v || w_en_p2;
    assign w_en_s3    = !r_s3_v || w_ds_ready;
    assign w_en_s2    = !r_s2_v || w_en_s3;
    assign w_en_s1    = !r_s1_v || w_en_s2;
    assign o_in_ready = w_en_s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_o_v  <= 1'b0;
        end else begin
            if (w_en_s1) r_s1_v <= i_in_valid;
            if (w_en_s2) r_s2_v <= r_s1_v;
            if (w_en_s3) r_s3_v <= r_s2_v;
            if (w_en_p1) r_p1_v <= w_ds_valid;
            if (w_en_p2) r_p2_v <= r_p1_v;
            if (w_en_o)  r_o_v  <= r_p2_v;
        end
    end

    // ---------------------------------------------------------------
    // S1: normal products and squared direction components
    // ---------------------------------------------------------------
    logic [ORG_W-1:0] w_mdx, w_mdy, w_mdz;
    assign w_mdx = i_dir_x[ORG_W-1] ? ORG_W'(-i_dir_x) : ORG_W'(i_dir_x);
    assign w_mdy = i_dir_y[ORG_W-1] ? ORG_W'(-i_dir_y) : ORG_W'(i_dir_y);
    assign w_mdz = i_dir_z[ORG_W-1] ? ORG_W'(-i_dir_z) : ORG_W'(i_dir_z);

    logic                     r_s1_kind;
    logic signed [PROD_W-1:0] r_s1_px, r_s1_py, r_s1_pz, r_s1_qx, r_s1_qy, r_s1_qz;
    logic [DW-1:0]            r_s1_sx, r_s1_sy, r_s1_sz;
    logic signed [ORG_W-1:0]  r_s1_ox, r_s1_oy, r_s1_oz;
    logic [2:0]               r_s1_dn;
    logic [ORG_W-1:0]         r_s1_mdx, r_s1_mdy, r_s1_mdz;

    always_ff @(posedge i_clk) begin
        if (w_en_s1 && i_in_valid) begin
            r_s1_kind <= i_kind;
            r_s1_px   <= PROD_W'(r_nx) * PROD_W'(i_origin_x);
            r_s1_py   <= PROD_W'(r_ny) * PROD_W'(i_origin_y);
            r_s1_pz   <= PROD_W'(r_nz) * PROD_W'(i_origin_z);
            r_s1_qx   <= PROD_W'(r_nx) * PROD_W'(i_dir_x);
            r_s1_qy   <= PROD_W'(r_ny) * PROD_W'(i_dir_y);
            r_s1_qz   <= PROD_W'(r_nz) * PROD_W'(i_dir_z);
            r_s1_sx   <= DW'(w_mdx) * DW'(w_mdx);
            r_s1_sy   <= DW'(w_mdy) * DW'(w_mdy);
            r_s1_sz   <= DW'(w_mdz) * DW'(w_mdz);
            r_s1_ox   <= i_origin_x;
            r_s1_oy   <= i_origin_y;
            r_s1_oz   <= i_origin_z;
            r_s1_dn   <= {i_dir_x[ORG_W-1], i_dir_y[ORG_W-1], i_dir_z[ORG_W-1]};
            r_s1_mdx  <= w_mdx;
            r_s1_mdy  <= w_mdy;
            r_s1_mdz  <= w_mdz;
        end
    end

    // ---------------------------------------------------------------
    // S2: N.o + D, N.d, d.d (exact)
    // ---------------------------------------------------------------
    logic                    r_s2_kind;
    logic signed [DOT_W-1:0] r_s2_no, r_s2_nd;
    logic [DW-1:0]           r_s2_dd;
    logic signed [ORG_W-1:0] r_s2_ox, r_s2_oy, r_s2_oz;
    logic [2:0]              r_s2_dn;
    logic [ORG_W-1:0]        r_s2_mdx, r_s2_mdy, r_s2_mdz;

    always_ff @(posedge i_clk) begin
        if (w_en_s2 && r_s1_v) begin
            r_s2_kind <= r_s1_kind;
            r_s2_no   <= DOT_W'(r_s1_px) + DOT_W'(r_s1_py) + DOT_W'(r_s1_pz)
                       + (DOT_W'(r_d) <<< FRAC_BITS);
            r_s2_nd   <= DOT_W'(r_s1_qx) + DOT_W'(r_s1_qy) + DOT_W'(r_s1_qz);
            r_s2_dd   <= r_s1_sx + r_s1_sy + r_s1_sz;
            r_s2_ox   <= r_s1_ox;
            r_s2_oy   <= r_s1_oy;
            r_s2_oz   <= r_s1_oz;
            r_s2_dn   <= r_s1_dn;
            r_s2_mdx  <= r_s1_mdx;
            r_s2_mdy  <= r_s1_mdy;
            r_s2_mdz  <= r_s1_mdz;
        end
    end

    // ---------------------------------------------------------------
    // S3: magnitudes, threshold tests, divider set-up
    // ---------------------------------------------------------------
    logic [MAG_W-1:0] w_nom, w_ndm, w_qr;
    logic [DW-1:0]    w_ddh;
    logic             n_par, n_near, n_same, n_ovf;
    logic [ORG_W-1:0] n_qrange;
    logic [CLP_W-1:0] n_ddc;

    assign w_nom    = r_s2_no[DOT_W-1] ? MAG_W'(-r_s2_no) : MAG_W'(r_s2_no);
    assign w_ndm    = r_s2_nd[DOT_W-1] ? MAG_W'(-r_s2_nd) : MAG_W'(r_s2_nd);
    assign n_par    = (w_ndm == '0) || (w_ndm < MAG_W'(w_eps2));
    assign n_near   = (w_nom < MAG_W'(w_eps2));
    assign n_same   = (r_s2_no[DOT_W-1] == r_s2_nd[DOT_W-1]);
    // |t| overflows 62 bits when the dividend's top part already reaches the divisor
    assign n_ovf    = (MAG_W'(w_nom >> (QW - FRAC_BITS)) >= w_ndm);
    assign w_qr     = w_nom >> FRAC_BITS;
    assign n_qrange = (w_qr > MAG_W'({ORG_W{1'b1}})) ? {ORG_W{1'b1}} : w_qr[ORG_W-1:0];
    // d.d >> F clamped to 2^EPS2_W; enough to decide the behind-origin compare
    assign w_ddh    = r_s2_dd >> FRAC_BITS;
    assign n_ddc    = (w_ddh >= (DW'(1) << EPS2_W)) ? (CLP_W'(1) << EPS2_W)
                                                    : CLP_W'(w_ddh);

    logic [MAG_W-1:0]  r_s3_nom, r_s3_ndm;
    logic [DW-1:0]     r_s3_dd;
    logic [SIDE_W-1:0] r_s3_side;

    always_ff @(posedge i_clk) begin
        if (w_en_s3 && r_s2_v) begin
            r_s3_nom  <= w_nom;
            r_s3_ndm  <= w_ndm;
            r_s3_dd   <= r_s2_dd;
            r_s3_side <= {r_s2_kind, n_par, n_same, n_ovf, n_near, n_qrange,
                          r_s2_ox, r_s2_oy, r_s2_oz, r_s2_dn,
                          r_s2_mdx, r_s2_mdy, r_s2_mdz, n_ddc};
        end
    end

    // ---------------------------------------------------------------
    // Divider / square root pipeline
    // ---------------------------------------------------------------
    logic [QW-1:0]     w_ds_q;
    logic [RW-1:0]     w_ds_root;
    logic [SIDE_W-1:0] w_ds_side;

    rpi_divsqrt #(
        .FRAC_BITS (FRAC_BITS),
        .MAG_W     (MAG_W),
        .SIDE_W    (SIDE_W)
    ) u_divsqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s3_v),
        .o_ready (w_ds_ready),
        .i_nom   (r_s3_nom),
        .i_ndm   (r_s3_ndm),
        .i_dd    (r_s3_dd),
        .i_side  (r_s3_side),
        .o_valid (w_ds_valid),
        .i_ready (w_en_p1),
        .o_quot  (w_ds_q),
        .o_root  (w_ds_root),
        .o_side  (w_ds_side)
    );

    logic                    w_kind, w_par, w_same, w_ovf, w_near;
    logic [ORG_W-1:0]        w_qrange;
    logic signed [ORG_W-1:0] w_ox, w_oy, w_oz;
    logic [2:0]              w_dn;
    logic [ORG_W-1:0]        w_mdx_d, w_mdy_d, w_mdz_d;
    logic [CLP_W-1:0]        w_ddc;

    assign {w_kind, w_par, w_same, w_ovf, w_near, w_qrange,
            w_ox, w_oy, w_oz, w_dn, w_mdx_d, w_mdy_d, w_mdz_d, w_ddc} = w_ds_side;

    // ---------------------------------------------------------------
    // P1: |t| with saturation, split partial products
    // ---------------------------------------------------------------
    logic [QW-1:0]     w_tm;
    logic [HALF_W-1:0] w_tm_hi, w_tm_lo;
    logic [CLP_W-1:0]  w_ta;

    assign w_tm    = w_ovf ? {QW{1'b1}} : w_ds_q;
    assign w_tm_hi = w_tm[QW-1:HALF_W];
    assign w_tm_lo = w_tm[HALF_W-1:0];
    assign w_ta    = (w_tm >= (QW'(1) << EPS2_W)) ? (CLP_W'(1) << EPS2_W) : CLP_W'(w_tm);

    logic                    r_p1_kind, r_p1_par, r_p1_tneg, r_p1_near;
    logic [ORG_W-1:0]        r_p1_qrange;
    logic signed [ORG_W-1:0] r_p1_ox, r_p1_oy, r_p1_oz;
    logic [2:0]              r_p1_dn;
    logic [MUL_W-1:0]        r_p1_mxh, r_p1_mxl, r_p1_myh, r_p1_myl, r_p1_mzh, r_p1_mzl;
    logic [MUL_W-1:0]        r_p1_mlh, r_p1_mll;
    logic [BH_W-1:0]         r_p1_bh;
    logic [BL_W-1:0]         r_p1_bl;

    always_ff @(posedge i_clk) begin
        if (w_en_p1 && w_ds_valid) begin
            r_p1_kind   <= w_kind;
            r_p1_par    <= w_par;
            r_p1_tneg   <= (w_tm != '0) && w_same;
            r_p1_near   <= w_near;
            r_p1_qrange <= w_qrange;
            r_p1_ox     <= w_ox;
            r_p1_oy     <= w_oy;
            r_p1_oz     <= w_oz;
            r_p1_dn     <= w_dn;
            r_p1_mxh    <= MUL_W'(w_tm_hi) * MUL_W'(w_mdx_d);
            r_p1_mxl    <= MUL_W'(w_tm_lo) * MUL_W'(w_mdx_d);
            r_p1_myh    <= MUL_W'(w_tm_hi) * MUL_W'(w_mdy_d);
            r_p1_myl    <= MUL_W'(w_tm_lo) * MUL_W'(w_mdy_d);
            r_p1_mzh    <= MUL_W'(w_tm_hi) * MUL_W'(w_mdz_d);
            r_p1_mzl    <= MUL_W'(w_tm_lo) * MUL_W'(w_mdz_d);
            r_p1_mlh    <= MUL_W'(w_tm_hi) * MUL_W'(w_ds_root);
            r_p1_mll    <= MUL_W'(w_tm_lo) * MUL_W'(w_ds_root);
            r_p1_bh     <= BH_W'(w_ta[CLP_W-1:AL]) * BH_W'(w_ddc);
            r_p1_bl     <= BL_W'(w_ta[AL-1:0]) * BL_W'(w_ddc);
        end
    end

    // ---------------------------------------------------------------
    // P2: combine partial products, saturate at 64 bits, drop fraction
    // ---------------------------------------------------------------
    function automatic logic [DW-1:0] sat_shr(input logic [MUL_W-1:0] hi,
                                              input logic [MUL_W-1:0] lo);
        logic [MPR_W-1:0] prod;
        prod = {hi, {HALF_W{1'b0}}} + MPR_W'(lo);
        if (|prod[MPR_W-1:DW]) begin
            sat_shr = {DW{1'b1}} >> FRAC_BITS;
        end else begin
            sat_shr = prod[DW-1:0] >> FRAC_BITS;
        end
    endfunction

    logic [BP_W-1:0] w_bp;
    assign w_bp = {r_p1_bh, {AL{1'b0}}} + BP_W'(r_p1_bl);

    logic                    r_p2_kind, r_p2_par, r_p2_behind, r_p2_near;
    logic [ORG_W-1:0]        r_p2_qrange;
    logic signed [ORG_W-1:0] r_p2_ox, r_p2_oy, r_p2_oz;
    logic [2:0]              r_p2_dn;
    logic [DW-1:0]           r_p2_px, r_p2_py, r_p2_pz, r_p2_plen;

    always_ff @(posedge i_clk) begin
        if (w_en_p2 && r_p1_v) begin
            r_p2_kind   <= r_p1_kind;
            r_p2_par    <= r_p1_par;
            r_p2_behind <= r_p1_tneg || (w_bp < BP_W'(w_eps2));
            r_p2_near   <= r_p1_near;
            r_p2_qrange <= r_p1_qrange;
            r_p2_ox     <= r_p1_ox;
            r_p2_oy     <= r_p1_oy;
            r_p2_oz     <= r_p1_oz;
            r_p2_dn     <= r_p1_dn;
            r_p2_px     <= sat_shr(r_p1_mxh, r_p1_mxl);
            r_p2_py     <= sat_shr(r_p1_myh, r_p1_myl);
            r_p2_pz     <= sat_shr(r_p1_mzh, r_p1_mzl);
            r_p2_plen   <= sat_shr(r_p1_mlh, r_p1_mll);
        end
    end

    // ---------------------------------------------------------------
    // P3: hit point o + t*d with clamp, result select, output register
    // ---------------------------------------------------------------
    function automatic logic [ORG_W-1:0] hit_coord(input logic signed [ORG_W-1:0] o,
                                                   input logic             dneg,
                                                   input logic [DW-1:0]    p);
        logic signed [HC_W-1:0] v;
        if (dneg && (p != '0)) begin
            v = HC_W'(o) - HC_W'(p);
        end else begin
            v = HC_W'(o) + HC_W'(p);
        end
        if ((&v[HC_W-1:ORG_W-1]) || !(|v[HC_W-1:ORG_W-1])) begin
            hit_coord = v[ORG_W-1:0];
        end else if (v[HC_W-1]) begin
            hit_coord = {1'b1, {(ORG_W-1){1'b0}}};
        end else begin
            hit_coord = {1'b0, {(ORG_W-1){1'b1}}};
        end
    endfunction

    rpi_pkg::t_status n_status;
    logic [ORG_W-1:0] n_hx, n_hy, n_hz, n_range;

    always_comb begin
        n_status = rpi_pkg::ST_HIT;
        n_hx     = '0;
        n_hy     = '0;
        n_hz     = '0;
        n_range  = '0;
        if (r_p2_kind) begin
            n_status = r_p2_near ? rpi_pkg::ST_HIT : rpi_pkg::ST_FAR;
            n_hx     = r_p2_ox;
            n_hy     = r_p2_oy;
            n_hz     = r_p2_oz;
            n_range  = r_p2_qrange;
        end else if (r_p2_par) begin
            n_status = rpi_pkg::ST_PARALLEL;
        end else if (r_p2_behind) begin
            n_status = rpi_pkg::ST_BEHIND;
        end else begin
            n_hx    = hit_coord(r_p2_ox, r_p2_dn[2], r_p2_px);
            n_hy    = hit_coord(r_p2_oy, r_p2_dn[1], r_p2_py);
            n_hz    = hit_coord(r_p2_oz, r_p2_dn[0], r_p2_pz);
            n_range = (r_p2_plen > DW'({ORG_W{1'b1}})) ? {ORG_W{1'b1}}
                                                       : r_p2_plen[ORG_W-1:0];
        end
    end

    rpi_pkg::t_status r_o_status;
    logic [ORG_W-1:0] r_o_hx, r_o_hy, r_o_hz, r_o_range;

    always_ff @(posedge i_clk) begin
        if (w_en_o && r_p2_v) begin
            r_o_status <= n_status;
            r_o_hx     <= n_hx;
            r_o_hy     <= n_hy;
            r_o_hz     <= n_hz;
            r_o_range  <= n_range;
        end
    end

    assign o_out_valid = r_o_v;
    assign o_status    = r_o_status;
    assign o_hit_x     = r_o_hx;
    assign o_hit_y     = r_o_hy;
    assign o_hit_z     = r_o_hz;
    assign o_range     = r_o_range;

endmodule

@@ hw/rtl/rpi_divsqrt.sv @@
// Pipelined restoring divider (one quotient bit per stage) with integer square root alongside.
`timescale 1ns / 1ps

module rpi_divsqrt #(
    parameter int FRAC_BITS = rpi_pkg::FRAC_BITS_DEF,
    parameter int MAG_W     = 51,
    parameter int SIDE_W    = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [MAG_W-1:0]          i_nom,
    input  logic [MAG_W-1:0]          i_ndm,
    input  logic [rpi_pkg::DD_W-1:0]  i_dd,
    input  logic [SIDE_W-1:0]         i_side,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [rpi_pkg::QUOT_W-1:0] o_quot,
    output logic [rpi_pkg::ROOT_W-1:0] o_root,
    output logic [SIDE_W-1:0]         o_side
);

    localparam int QW  = rpi_pkg::QUOT_W;
    localparam int RW  = rpi_pkg::ROOT_W;
    localparam int DW  = rpi_pkg::DD_W;
    localparam int SRW = RW + 2;
    localparam int NS  = QW;

    logic [NS-1:0]     r_v;
    logic [NS-1:0]     w_en;
    logic [MAG_W-1:0]  r_rem  [NS];
    logic [MAG_W-1:0]  r_ndm  [NS];
    logic [QW-1:0]     r_dvs  [NS];
    logic [QW-1:0]     r_q    [NS];
    logic [SRW-1:0]    r_srem [NS];
    logic [RW-1:0]     r_root [NS];
    logic [DW-1:0]     r_dds  [NS];
    logic [SIDE_W-1:0] r_side [NS];

    // Dividend is nom << FRAC_BITS; bits above the 62 quotient positions seed the remainder
    logic [MAG_W-1:0] w_rem0;
    logic [QW-1:0]    w_dvs0;
    assign w_rem0 = MAG_W'(i_nom >> (QW - FRAC_BITS));
    assign w_dvs0 = QW'({i_nom, {FRAC_BITS{1'b0}}});

    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic              w_vin;
        logic [MAG_W-1:0]  w_rem_i;
        logic [MAG_W-1:0]  w_ndm_i;
        logic [QW-1:0]     w_dvs_i;
        logic [QW-1:0]     w_q_i;
        logic [SRW-1:0]    w_srem_i;
        logic [RW-1:0]     w_root_i;
        logic [DW-1:0]     w_dds_i;
        logic [SIDE_W-1:0] w_side_i;
        logic [MAG_W:0]    w_r2;
        logic              w_ge;
        logic [MAG_W-1:0]  n_rem;
        logic [SRW-1:0]    n_srem;
        logic [RW-1:0]     n_root;
        logic [DW-1:0]     n_dds;

        if (k == 0) begin : g_first
            assign w_vin    = i_valid;
            assign w_rem_i  = w_rem0;
            assign w_ndm_i  = i_ndm;
            assign w_dvs_i  = w_dvs0;
            assign w_q_i    = '0;
            assign w_srem_i = '0;
            assign w_root_i = '0;
            assign w_dds_i  = i_dd;
            assign w_side_i = i_side;
        end else begin : g_next
            assign w_vin    = r_v[k-1];
            assign w_rem_i  = r_rem[k-1];
            assign w_ndm_i  = r_ndm[k-1];
            assign w_dvs_i  = r_dvs[k-1];
            assign w_q_i    = r_q[k-1];
            assign w_srem_i = r_srem[k-1];
            assign w_root_i = r_root[k-1];
            assign w_dds_i  = r_dds[k-1];
            assign w_side_i = r_side[k-1];
        end

        if (k == NS - 1) begin : g_last_en
            assign w_en[k] = !r_v[k] || i_ready;
        end else begin : g_mid_en
            assign w_en[k] = !r_v[k] || w_en[k+1];
        end

        // divide step
        assign w_r2  = {w_rem_i, w_dvs_i[QW-1]};
        assign w_ge  = (w_r2 >= {1'b0, w_ndm_i});
        assign n_rem = w_ge ? MAG_W'(w_r2 - {1'b0, w_ndm_i}) : MAG_W'(w_r2);

        // square root step, two radicand bits per step
        if (k < RW) begin : g_sqrt
            logic [SRW-1:0] w_sr2;
            logic [SRW-1:0] w_trial;
            logic           w_sge;
            assign w_sr2   = {w_srem_i[RW-1:0], w_dds_i[DW-1 -: 2]};
            assign w_trial = {w_root_i, 2'b01};
            assign w_sge   = (w_sr2 >= w_trial);
            assign n_srem  = w_sge ? (w_sr2 - w_trial) : w_sr2;
            assign n_root  = {w_root_i[RW-2:0], w_sge};
            assign n_dds   = {w_dds_i[DW-3:0], 2'b00};
        end else begin : g_hold
            assign n_srem = w_srem_i;
            assign n_root = w_root_i;
            assign n_dds  = w_dds_i;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_en[k]) begin
                r_v[k] <= w_vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[k] && w_vin) begin
                r_rem[k]  <= n_rem;
                r_ndm[k]  <= w_ndm_i;
                r_dvs[k]  <= {w_dvs_i[QW-2:0], 1'b0};
                r_q[k]    <= {w_q_i[QW-2:0], w_ge};
                r_srem[k] <= n_srem;
                r_root[k] <= n_root;
                r_dds[k]  <= n_dds;
                r_side[k] <= w_side_i;
            end
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[NS-1];
    assign o_quot  = r_q[NS-1];
    assign o_root  = r_root[NS-1];
    assign o_side  = r_side[NS-1];

endmodule

@@ verif/tb_ray_plane_intersect_top.sv @@
// Testbench for the ray/plane intersection pipeline: directed and random rays and queries.
`timescale 1ns / 1ps

module tb_ray_plane_intersect_top;

    localparam int FB = rpi_pkg::FRAC_BITS_DEF;
    localparam logic [63:0] TMAG_SAT = (64'd1 << 62) - 64'd1;
    localparam logic [63:0] U64_MAX = {64{1'b1}};

    // one expected result
    typedef struct {
        rpi_pkg::t_status status;
        logic [31:0]      hx, hy, hz, rng;
    } t_hit_rec;

    // Plane state plus queue of pending results
    class hit_board;
        longint nx, ny, nz, ofs;
        logic [63:0] eps;
        t_hit_rec pending[$];
        int errors;

        function void reset_plane();
            nx = 0; ny = 0; nz = 64'sd1 << FB; ofs = 0; eps = 7;
            errors = 0;
        endfunction

        function void write_reg(rpi_pkg::t_cfg_idx idx, logic [31:0] val);
            case (idx)
                rpi_pkg::CFG_NORMAL_X: nx = longint'($signed(val[17:0]));
                rpi_pkg::CFG_NORMAL_Y: ny = longint'($signed(val[17:0]));
                rpi_pkg::CFG_NORMAL_Z: nz = longint'($signed(val[17:0]));
                rpi_pkg::CFG_OFFSET:   ofs = longint'($signed(val));
                rpi_pkg::CFG_EPSILON:  eps = {48'd0, val[15:0]};
                default: ;
            endcase
        endfunction

        static function logic [63:0] magn(longint v);
            return v < 0 ? 64'd0 - 64'(v) : 64'(v);
        endfunction

        static function logic [63:0] mul_sat(logic [63:0] a, logic [63:0] b);
            logic [127:0] p;
            p = a * b;
            return p[127:64] != 0 ? U64_MAX : p[63:0];
        endfunction

        static function logic [63:0] root64(logic [63:0] v);
            logic [63:0] res, b;
            res = 0; b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v -= res + b;
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        static function logic [31:0] clip32(longint v);
            if (v > 64'sd2147483647) return 32'h7fffffff;
            if (v < -64'sd2147483648) return 32'h80000000;
            return v[31:0];
        endfunction

        static function logic [31:0] coord(longint o, logic [63:0] tm, longint d);
            logic [63:0] p;
            p = mul_sat(tm, magn(d)) >> FB;
            // p >= 2^48 always saturates; keep it in range of longint
            if (p > 64'h0000_7fff_ffff_ffff) p = 64'h0000_7fff_ffff_ffff;
            return clip32(d < 0 ? o - longint'(p) : o + longint'(p));
        endfunction

        // predict the result of one accepted transaction
        function void note_input(logic k, logic [31:0] o[3], logic [31:0] d[3]);
            t_hit_rec e;
            longint ox, oy, oz, dx, dy, dz, no, nd;
            logic [63:0] nom, ndm, eps2, q, r, tm, dd, sq;
            bit tneg;
            ox = $signed(o[0]); oy = $signed(o[1]); oz = $signed(o[2]);
            dx = $signed(d[0]); dy = $signed(d[1]); dz = $signed(d[2]);
            eps2 = eps << FB;
            no = nx * ox + ny * oy + nz * oz + ofs * (64'sd1 << FB);
            nom = magn(no);
            e = '{rpi_pkg::ST_HIT, 0, 0, 0, 0};
            if (k) begin
                r = nom >> FB;
                e.status = nom < eps2 ? rpi_pkg::ST_HIT : rpi_pkg::ST_FAR;
                e.hx = o[0]; e.hy = o[1]; e.hz = o[2];
                e.rng = r > 64'hffffffff ? 32'hffffffff : r[31:0];
            end else begin
                nd = nx * dx + ny * dy + nz * dz;
                ndm = magn(nd);
                if (ndm == 0 || ndm < eps2) begin
                    e.status = rpi_pkg::ST_PARALLEL;
                end else begin
                    q = nom / ndm;
                    r = nom % ndm;
                    if (q > (TMAG_SAT >> FB)) begin
                        tm = TMAG_SAT;
                    end else begin
                        tm = q;
                        for (int i = 0; i < FB; i++) begin
                            r <<= 1; tm <<= 1;
                            if (r >= ndm) begin
                                r -= ndm; tm |= 1;
                            end
                        end
                    end
                    tneg = (tm != 0) && ((no < 0) == (nd < 0));
                    dd = mul_sat(magn(dx), magn(dx)) + mul_sat(magn(dy), magn(dy));
                    dd += mul_sat(magn(dz), magn(dz));
                    if (tneg || mul_sat(tm, dd >> FB) < eps2) begin
                        e.status = rpi_pkg::ST_BEHIND;
                    end else begin
                        e.hx = coord(ox, tm, dx);
                        e.hy = coord(oy, tm, dy);
                        e.hz = coord(oz, tm, dz);
                        sq = mul_sat(tm, root64(dd)) >> FB;
                        e.rng = sq > 64'hffffffff ? 32'hffffffff : sq[31:0];
                    end
                end
            end
            pending.push_back(e);
        endfunction

        function void check_result(logic [1:0] st, logic [31:0] hx, logic [31:0] hy,
                                   logic [31:0] hz, logic [31:0] rng);
            t_hit_rec e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result status %0d", $time, st);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (st !== e.status) begin
                $display("%0t: status exp %0d got %0d", $time, e.status, st); errors++;
            end
            if (hx !== e.hx) begin
                $display("%0t: hit_x exp %h got %h", $time, e.hx, hx); errors++;
            end
            if (hy !== e.hy) begin
                $display("%0t: hit_y exp %h got %h", $time, e.hy, hy); errors++;
            end
            if (hz !== e.hz) begin
                $display("%0t: hit_z exp %h got %h", $time, e.hz, hz); errors++;
            end
            if (rng !== e.rng) begin
                $display("%0t: range exp %h got %h", $time, e.rng, rng); errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_in_valid = 0;
    logic        o_in_ready;
    logic        i_kind = 0;
    logic signed [31:0] i_origin_x = 0, i_origin_y = 0, i_origin_z = 0;
    logic signed [31:0] i_dir_x = 0, i_dir_y = 0, i_dir_z = 0;
    logic        o_out_valid;
    logic        i_out_ready = 0;
    logic [1:0]  o_status;
    logic signed [31:0] o_hit_x, o_hit_y, o_hit_z;
    logic [31:0] o_range;

    hit_board board;
    bit quiet_in, quiet_out;   // stretches with no idling

    ray_plane_intersect_top i_dut (.*);

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    // Result side: random stalls, check every accepted transaction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                board.check_result(o_status, o_hit_x, o_hit_y, o_hit_z, o_range);
            i_out_ready <= quiet_out || ($urandom_range(99) >= 11);
        end
    end

    task automatic cfg_write(rpi_pkg::t_cfg_idx idx, logic [31:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_reg(idx, val);
        i_cfg_valid <= 0;
    endtask

    // Drive one transaction; valid stays up across back-to-back transactions
    task automatic send_item(logic k, logic [31:0] o[3], logic [31:0] d[3]);
        while (!quiet_in && $urandom_range(99) < 11) begin
            i_in_valid <= 0;
            @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_kind <= k;
        {i_origin_x, i_origin_y, i_origin_z} <= {o[0], o[1], o[2]};
        {i_dir_x, i_dir_y, i_dir_z} <= {d[0], d[1], d[2]};
        do @(posedge i_clk); while (!o_in_ready);
        board.note_input(k, o, d);
    endtask

    // drain the pipeline before touching the plane registers
    task automatic wait_idle();
        i_in_valid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(5))
            0: return $urandom();
            1: return $urandom_range(3) == 0 ? 32'h80000000 : 32'h7fffffff;
            default: return 32'($signed($urandom_range(20 << 16)) - (10 << 16));
        endcase
    endfunction

    function automatic logic [31:0] rnd_normal();
        case ($urandom_range(4))
            0: return 32'h10000;
            1: return 32'hffff0000;
            2: return 32'($urandom_range(131072) - 65536);
            default: return 32'($urandom_range(92682) - 46341);
        endcase
    endfunction

    // Random batch of rays and queries; ray directions mostly within +/-4.0
    task automatic random_batch(int n);
        logic [31:0] o[3], d[3];
        for (int i = 0; i < n; i++) begin
            quiet_in = (i >= n / 2) && (i < n / 2 + 40);
            quiet_out = quiet_in;
            foreach (o[j]) o[j] = rnd_coord();
            foreach (d[j]) d[j] = $urandom_range(3) == 0 ? rnd_coord()
                                 : 32'($signed($urandom_range(8 << 16)) - (4 << 16));
            send_item($urandom_range(3) == 0, o, d);
        end
        quiet_in = 0; quiet_out = 0;
    endtask

    initial begin
        logic [31:0] o[3], d[3];
        board = new();
        board.reset_plane();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: reset plane z = 0
        o = '{0, 0, 32'h50000};       d = '{0, 0, 32'hffff0000};   // hit
        send_item(0, o, d);
        d = '{32'h10000, 0, 0};                                   // parallel
        send_item(0, o, d);
        d = '{0, 0, 32'h10000};                                   // behind
        send_item(0, o, d);
        d = '{0, 0, 32'd3};                                       // |N.d| under epsilon
        send_item(0, o, d);
        o = '{32'h7fffffff, 32'h80000000, 32'h7fffffff};
        d = '{32'h7fffffff, 32'h80000000, 32'h80000000};          // saturation
        send_item(0, o, d);
        o = '{32'h80000000, 32'h7fffffff, 32'h80000000};
        d = '{32'h80000000, 32'h7fffffff, 32'h00000001};          // huge t
        send_item(0, o, d);
        o = '{0, 0, 0};               d = '{0, 0, 32'h10000};     // origin on plane
        send_item(0, o, d);
        o = '{1, 2, 32'd6};           d = '{0, 0, 0};             // near query
        send_item(1, o, d);
        o = '{1, 2, 32'd7};                                       // just not near
        send_item(1, o, d);
        o = '{0, 0, 32'h80000000};                                // far query
        send_item(1, o, d);
        o = '{32'hffffffff, 32'hffffffff, 32'hffffffff};
        d = '{32'hffffffff, 32'hffffffff, 32'hffffffff};
        send_item(0, o, d);
        send_item(1, o, d);
        wait_idle();

        // Extreme plane: tilted normal at bounds, largest offset and epsilon
        cfg_write(rpi_pkg::CFG_NORMAL_X, 32'hfffe0000);
        cfg_write(rpi_pkg::CFG_NORMAL_Y, 32'h10000);
        cfg_write(rpi_pkg::CFG_NORMAL_Z, 32'h0);
        cfg_write(rpi_pkg::CFG_OFFSET, 32'h7fffffff);
        cfg_write(rpi_pkg::CFG_EPSILON, 32'hffff);
        random_batch(60);
        wait_idle();
        cfg_write(rpi_pkg::CFG_OFFSET, 32'h80000000);
        cfg_write(rpi_pkg::CFG_EPSILON, 32'h0);
        random_batch(60);
        wait_idle();

        for (int p = 0; p < 6; p++) begin
            cfg_write(rpi_pkg::CFG_NORMAL_X, rnd_normal());
            cfg_write(rpi_pkg::CFG_NORMAL_Y, rnd_normal());
            cfg_write(rpi_pkg::CFG_NORMAL_Z, rnd_normal());
            cfg_write(rpi_pkg::CFG_OFFSET, p[0] ? $urandom() : rnd_coord());
            cfg_write(rpi_pkg::CFG_EPSILON, $urandom_range(p[1] ? 65535 : 64));
            random_batch(105);
            wait_idle();
        end

        if (board.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Verification failed");
        $finish;
    end
endmodule
